// ===== hw/rtl/wbca_pkg.sv =====
package wbca_pkg;

  localparam int WORDS_PER_PAGE = 8;
  localparam int PAGES          = 16;
  localparam int WORD_BITS      = 64;

  localparam int TOTAL_WORDS = WORDS_PER_PAGE * PAGES;
  localparam int TOTAL_BITS  = TOTAL_WORDS * WORD_BITS;

  localparam int IDX_W  = 14;
  localparam int ADDR_W = $clog2(TOTAL_WORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);

  localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = WORD_BITS;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [IDX_W-1:0]     idx_t;

endpackage

// ===== hw/rtl/wide_bitmap_carry_adder.sv =====
// Wide bitmap carry adder: holds one TOTAL_WORDS x 64-bit number (word 0 most
// significant, bit position 1 = its MSB) in a single-port-read/single-port-write
// RAM, cleared at reset through per-word valid bits so no clearing pass is needed.
// Each input transaction with a non-zero index adds a one at that bit position
// with full carry towards word 0; a carry out of word 0 is lost. Every input
// yields exactly one output transaction holding word 0 after the update (zero
// for index 0; an index beyond the number changes nothing). Index 0 or out of
// range is answered from the idle state; otherwise the addressed word is read,
// then updated in S_RMW, with one more read-modify-write for each further word
// the carry ripples into, as the RAM does one read-modify-write per cycle. A
// finished result sits in the output register while the next input is taken.
module wide_bitmap_carry_adder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wbca_pkg::IN_TDATA_W-1:0]    in_tdata,   // [13:0] index, rest zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wbca_pkg::OUT_TDATA_W-1:0]   out_tdata   // [63:0] top_word
);

  import wbca_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_HOLD
  } state_t;

  state_t                 state_r, state_nxt;
  addr_t                  addr_r, addr_nxt;
  word_t                  addend_r, addend_nxt;
  word_t                  top_r, top_nxt;        // mirror of word 0
  word_t                  res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  word_t                  out_data_r, out_data_nxt;
  logic [TOTAL_WORDS-1:0] vld_r, vld_nxt;

  logic           rd_en;
  addr_t          rd_addr;
  logic           wr_en;
  word_t          rdata;
  word_t          rdata_m;
  logic [WORD_BITS:0] sum;
  idx_t           idx;
  idx_t           pos;
  addr_t          word_idx;
  logic [BIT_W-1:0] bit_idx;
  logic           slot_free;
  logic           fin_req;
  word_t          fin_val;

  wbca_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TOTAL_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(addr_r),
    .wdata(sum[WORD_BITS-1:0]),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign idx      = in_tdata[IDX_W-1:0];
  assign pos      = idx - IDX_W'(1);
  assign word_idx = ADDR_W'(pos[IDX_W-1:BIT_W]);
  assign bit_idx  = BIT_W'(WORD_BITS - 1) - pos[BIT_W-1:0];

  // never-written words read as zero
  assign rdata_m = vld_r[addr_r] ? rdata : '0;
  assign sum     = {1'b0, rdata_m} + {1'b0, addend_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    addend_nxt    = addend_r;
    top_nxt       = top_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    vld_nxt       = vld_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    fin_req       = 1'b0;
    fin_val       = top_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (idx == '0) begin
            fin_req = 1'b1;
            fin_val = '0;
          end else if (idx > IDX_W'(TOTAL_BITS)) begin
            fin_req = 1'b1;
            fin_val = top_r;
          end else begin
            addr_nxt   = word_idx;
            addend_nxt = word_t'(1) << bit_idx;
            rd_en      = 1'b1;
            rd_addr    = word_idx;
            state_nxt  = S_RMW;
          end
        end
      end
      S_RMW: begin
        wr_en           = 1'b1;
        vld_nxt[addr_r] = 1'b1;
        if (addr_r == '0) begin
          top_nxt = sum[WORD_BITS-1:0];
        end
        if (sum[WORD_BITS] && (addr_r != '0)) begin
          // ripple the carry into the next more significant word
          addr_nxt   = addr_r - ADDR_W'(1);
          addend_nxt = word_t'(1);
          rd_en      = 1'b1;
          rd_addr    = addr_r - ADDR_W'(1);
        end else begin
          fin_req = 1'b1;
          fin_val = (addr_r == '0) ? sum[WORD_BITS-1:0] : top_r;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_req) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fin_val;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = fin_val;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      top_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      top_r       <= top_nxt;
    end
    addr_r     <= addr_nxt;
    addend_r   <= addend_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/wbca_ram.sv =====
module wbca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
